[sv/llac_pkg.sv]
// ----------------------------------------------------------------------------
// llac_pkg: shared types, constants and microcode for the light accumulator
// Widths of the Q4.12 datapath, register indexes, control word layout and
// the microcode program that sequences one input word.
// ----------------------------------------------------------------------------
package llac_pkg;

	// Data widths: Q4.12 words, Q12.12 accumulators, one 24x16 multiplier.
	localparam int DW   = 16;
	localparam int AW   = DW + 8;
	localparam int PW   = AW + DW;
	localparam int FB   = 12;
	localparam int QW   = PW - FB;
	localparam int SW   = QW + 1;
	localparam int DOTW = 2 * DW - FB + 2;
	localparam int STW  = 5;
	localparam int ADW  = 5;
	localparam int PDW  = 32;

	// Register reset values.
	localparam logic signed [DW-1:0] REFL_RST   = DW'(3277);
	localparam logic signed [DW-1:0] COL_R_RST  = DW'(0);
	localparam logic signed [DW-1:0] COL_G_RST  = DW'(2409);
	localparam logic signed [DW-1:0] COL_B_RST  = DW'(2638);
	localparam logic signed [DW-1:0] GLOW_RST   = DW'(0);

	// Register indexes (byte address divided by four).
	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_REFL   = 3'd0;
	localparam reg_idx_t REG_COL_R  = 3'd1;
	localparam reg_idx_t REG_COL_G  = 3'd2;
	localparam reg_idx_t REG_COL_B  = 3'd3;
	localparam reg_idx_t REG_GLOW_R = 3'd4;
	localparam reg_idx_t REG_GLOW_G = 3'd5;
	localparam reg_idx_t REG_GLOW_B = 3'd6;

	// Operation codes of an input word.
	localparam logic OP_BEGIN = 1'b0;
	localparam logic OP_LIGHT = 1'b1;

	// Multiplier operand A selects (24-bit side).
	typedef logic [3:0] a_sel_t;
	localparam a_sel_t A_VX    = 4'd0;
	localparam a_sel_t A_VY    = 4'd1;
	localparam a_sel_t A_VZ    = 4'd2;
	localparam a_sel_t A_DOT   = 4'd3;
	localparam a_sel_t A_LR    = 4'd4;
	localparam a_sel_t A_LG    = 4'd5;
	localparam a_sel_t A_LB    = 4'd6;
	localparam a_sel_t A_ACC_R = 4'd7;
	localparam a_sel_t A_ACC_G = 4'd8;
	localparam a_sel_t A_ACC_B = 4'd9;

	// Multiplier operand B selects (16-bit side).
	typedef logic [2:0] b_sel_t;
	localparam b_sel_t B_NX    = 3'd0;
	localparam b_sel_t B_NY    = 3'd1;
	localparam b_sel_t B_NZ    = 3'd2;
	localparam b_sel_t B_REFL  = 3'd3;
	localparam b_sel_t B_WGT   = 3'd4;
	localparam b_sel_t B_COL_R = 3'd5;
	localparam b_sel_t B_COL_G = 3'd6;
	localparam b_sel_t B_COL_B = 3'd7;

	// Writeback destinations of the scaled product.
	typedef logic [3:0] wb_t;
	localparam wb_t WB_NONE    = 4'd0;
	localparam wb_t WB_DOT_CLR = 4'd1;
	localparam wb_t WB_DOT_ADD = 4'd2;
	localparam wb_t WB_WGT     = 4'd3;
	localparam wb_t WB_ACC_R   = 4'd4;
	localparam wb_t WB_ACC_G   = 4'd5;
	localparam wb_t WB_ACC_B   = 4'd6;
	localparam wb_t WB_OUT_R   = 4'd7;
	localparam wb_t WB_OUT_G   = 4'd8;
	localparam wb_t WB_OUT_B   = 4'd9;

	// Jump conditions.
	typedef logic [2:0] jmp_t;
	localparam jmp_t J_NEVER    = 3'd0;
	localparam jmp_t J_ALWAYS   = 3'd1;
	localparam jmp_t J_BEGIN    = 3'd2;
	localparam jmp_t J_NO_DIFF  = 3'd3;
	localparam jmp_t J_DOT_LE0  = 3'd4;
	localparam jmp_t J_NOT_LAST = 3'd5;
	localparam jmp_t J_LAST     = 3'd6;

	// Program step addresses.
	typedef logic [STW-1:0] step_t;
	localparam step_t ST_DISPATCH = 5'd0;
	localparam step_t ST_AMB      = 5'd1;
	localparam step_t ST_DOT_X    = 5'd2;
	localparam step_t ST_DOT_Y    = 5'd3;
	localparam step_t ST_DOT_Z    = 5'd4;
	localparam step_t ST_DOT_SUM  = 5'd5;
	localparam step_t ST_WGT_MUL  = 5'd6;
	localparam step_t ST_WGT      = 5'd7;
	localparam step_t ST_DIF_R    = 5'd8;
	localparam step_t ST_DIF_G    = 5'd9;
	localparam step_t ST_DIF_B    = 5'd10;
	localparam step_t ST_DIF_ACC  = 5'd11;
	localparam step_t ST_CHK_LAST = 5'd12;
	localparam step_t ST_OUT_R    = 5'd13;
	localparam step_t ST_OUT_G    = 5'd14;
	localparam step_t ST_OUT_B    = 5'd15;
	localparam step_t ST_EMIT     = 5'd16;
	localparam step_t ST_BEG      = 5'd17;
	localparam step_t ST_DONE     = 5'd18;

	// Payload of one input word.
	typedef struct packed {
		logic                 operation;
		logic signed [DW-1:0] vec_x;
		logic signed [DW-1:0] vec_y;
		logic signed [DW-1:0] vec_z;
		logic signed [DW-1:0] light_red;
		logic signed [DW-1:0] light_green;
		logic signed [DW-1:0] light_blue;
		logic                 ambient_on;
		logic                 diffuse_on;
		logic                 last_item;
	} in_item_t;

	// Payload of one result word.
	typedef struct packed {
		logic signed [DW-1:0] out_red;
		logic signed [DW-1:0] out_green;
		logic signed [DW-1:0] out_blue;
	} out_item_t;

	// Configuration register file contents.
	typedef struct packed {
		logic signed [DW-1:0] refl;
		logic signed [DW-1:0] col_r;
		logic signed [DW-1:0] col_g;
		logic signed [DW-1:0] col_b;
		logic signed [DW-1:0] glow_r;
		logic signed [DW-1:0] glow_g;
		logic signed [DW-1:0] glow_b;
	} cfg_t;

	// One microcode control word.
	typedef struct packed {
		logic   mul_en;
		a_sel_t a_sel;
		b_sel_t b_sel;
		wb_t    wb;
		logic   amb;
		logic   load_nrm;
		logic   emit;
		logic   wait_out;
		jmp_t   jmp;
		step_t  target;
		logic   done;
	} ctrl_t;

	// Datapath status seen by the sequencer.
	typedef struct packed {
		logic is_begin;
		logic no_diff;
		logic dot_le0;
		logic last;
		logic out_hold;
	} stat_t;

	// Microcode ROM: one control word per step.
	function automatic ctrl_t ucode(input step_t step);
		ctrl_t w;
		w = '0;
		case (step)
			ST_DISPATCH: begin
				w.jmp = J_BEGIN;
				w.target = ST_BEG;
			end
			ST_AMB: begin
				w.amb = 1'b1;
				w.jmp = J_NO_DIFF;
				w.target = ST_CHK_LAST;
			end
			ST_DOT_X: begin
				w.mul_en = 1'b1;
				w.a_sel = A_VX;
				w.b_sel = B_NX;
			end
			ST_DOT_Y: begin
				w.mul_en = 1'b1;
				w.a_sel = A_VY;
				w.b_sel = B_NY;
				w.wb = WB_DOT_CLR;
			end
			ST_DOT_Z: begin
				w.mul_en = 1'b1;
				w.a_sel = A_VZ;
				w.b_sel = B_NZ;
				w.wb = WB_DOT_ADD;
			end
			ST_DOT_SUM: begin
				w.wb = WB_DOT_ADD;
			end
			ST_WGT_MUL: begin
				w.mul_en = 1'b1;
				w.a_sel = A_DOT;
				w.b_sel = B_REFL;
				w.jmp = J_DOT_LE0;
				w.target = ST_CHK_LAST;
			end
			ST_WGT: begin
				w.wb = WB_WGT;
			end
			ST_DIF_R: begin
				w.mul_en = 1'b1;
				w.a_sel = A_LR;
				w.b_sel = B_WGT;
			end
			ST_DIF_G: begin
				w.mul_en = 1'b1;
				w.a_sel = A_LG;
				w.b_sel = B_WGT;
				w.wb = WB_ACC_R;
			end
			ST_DIF_B: begin
				w.mul_en = 1'b1;
				w.a_sel = A_LB;
				w.b_sel = B_WGT;
				w.wb = WB_ACC_G;
			end
			ST_DIF_ACC: begin
				w.wb = WB_ACC_B;
			end
			ST_CHK_LAST: begin
				w.jmp = J_NOT_LAST;
				w.target = ST_DONE;
			end
			ST_OUT_R: begin
				w.wait_out = 1'b1;
				w.mul_en = 1'b1;
				w.a_sel = A_ACC_R;
				w.b_sel = B_COL_R;
			end
			ST_OUT_G: begin
				w.mul_en = 1'b1;
				w.a_sel = A_ACC_G;
				w.b_sel = B_COL_G;
				w.wb = WB_OUT_R;
			end
			ST_OUT_B: begin
				w.mul_en = 1'b1;
				w.a_sel = A_ACC_B;
				w.b_sel = B_COL_B;
				w.wb = WB_OUT_G;
			end
			ST_EMIT: begin
				w.wb = WB_OUT_B;
				w.emit = 1'b1;
				w.done = 1'b1;
			end
			ST_BEG: begin
				w.load_nrm = 1'b1;
				w.jmp = J_LAST;
				w.target = ST_OUT_R;
			end
			default: begin
				w.done = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

[sv/llac_if.sv]
// ----------------------------------------------------------------------------
// llac_if: valid/ready channels of the light accumulator
// One interface for the input word stream and one for the result stream.
// ----------------------------------------------------------------------------
interface llac_in_if import llac_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface llac_out_if import llac_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

[sv/llac_cfg.sv]
// ----------------------------------------------------------------------------
// llac_cfg: APB register file
// Holds reflectivity, surface color and glow; writes at the access phase,
// reads return the sign-extended register value.
// ----------------------------------------------------------------------------
module llac_cfg import llac_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [ADW-1:0] paddr,
	input  logic [PDW-1:0] pwdata,
	output logic [PDW-1:0] prdata,
	output logic           pready,
	output cfg_t           cfg
);

	cfg_t                 cfg_q;
	reg_idx_t             idx;
	logic                 wr_en;
	logic signed [DW-1:0] wdata;
	logic signed [DW-1:0] rdata;

	assign pready = 1'b1;
	assign idx    = paddr[ADW-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign wdata  = pwdata[DW-1:0];
	assign cfg    = cfg_q;

	// Register writes; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.refl   <= REFL_RST;
			cfg_q.col_r  <= COL_R_RST;
			cfg_q.col_g  <= COL_G_RST;
			cfg_q.col_b  <= COL_B_RST;
			cfg_q.glow_r <= GLOW_RST;
			cfg_q.glow_g <= GLOW_RST;
			cfg_q.glow_b <= GLOW_RST;
		end else if (wr_en) begin
			case (idx)
				REG_REFL:   cfg_q.refl   <= wdata;
				REG_COL_R:  cfg_q.col_r  <= wdata;
				REG_COL_G:  cfg_q.col_g  <= wdata;
				REG_COL_B:  cfg_q.col_b  <= wdata;
				REG_GLOW_R: cfg_q.glow_r <= wdata;
				REG_GLOW_G: cfg_q.glow_g <= wdata;
				REG_GLOW_B: cfg_q.glow_b <= wdata;
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		case (idx)
			REG_REFL:   rdata = cfg_q.refl;
			REG_COL_R:  rdata = cfg_q.col_r;
			REG_COL_G:  rdata = cfg_q.col_g;
			REG_COL_B:  rdata = cfg_q.col_b;
			REG_GLOW_R: rdata = cfg_q.glow_r;
			REG_GLOW_G: rdata = cfg_q.glow_g;
			REG_GLOW_B: rdata = cfg_q.glow_b;
			default:    rdata = '0;
		endcase
	end

	assign prdata = {{(PDW-DW){rdata[DW-1]}}, rdata};

endmodule

[sv/llac_seq.sv]
// ----------------------------------------------------------------------------
// llac_seq: microcode sequencer
// Step counter over the microcode ROM with conditional jumps; it issues one
// control word per cycle while a word is in work and holds on a full output.
// ----------------------------------------------------------------------------
module llac_seq import llac_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output logic  busy,
	output ctrl_t ctrl
);

	logic  busy_q;
	step_t step_q;
	ctrl_t word;
	logic  stall;
	logic  take;

	// Fetch the current control word and gate it while idle or stalled.
	always_comb begin
		word  = ucode(step_q);
		stall = word.wait_out && stat.out_hold;
		ctrl  = (busy_q && !stall) ? word : '0;
	end

	// Jump condition evaluation.
	always_comb begin
		case (word.jmp)
			J_NEVER:    take = 1'b0;
			J_ALWAYS:   take = 1'b1;
			J_BEGIN:    take = stat.is_begin;
			J_NO_DIFF:  take = stat.no_diff;
			J_DOT_LE0:  take = stat.dot_le0;
			J_NOT_LAST: take = !stat.last;
			J_LAST:     take = stat.last;
			default:    take = 1'b0;
		endcase
	end

	// Step counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= ST_DISPATCH;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= ST_DISPATCH;
		end else if (busy_q && !stall) begin
			if (word.done) begin
				busy_q <= 1'b0;
			end
			step_q <= take ? word.target : step_q + STW'(1);
		end
	end

	assign busy = busy_q;

endmodule

[sv/llac_dpath.sv]
// ----------------------------------------------------------------------------
// llac_dpath: shading datapath
// One shared 24x16 multiplier with a product register, the normal and
// accumulator state, the dot and weight registers and the result register.
// ----------------------------------------------------------------------------
module llac_dpath import llac_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  in_item_t  in_item,
	input  cfg_t      cfg,
	input  ctrl_t     ctrl,
	input  logic      out_ready,
	output stat_t     stat,
	output logic      out_valid,
	output out_item_t out_item
);

	// Saturate a wide value to a data word.
	function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] x);
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] lo;
		hi = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
		lo = ~hi;
		if (x > hi) begin
			return hi[DW-1:0];
		end else if (x < lo) begin
			return lo[DW-1:0];
		end
		return x[DW-1:0];
	endfunction

	// Saturate a wide value to an accumulator word.
	function automatic logic signed [AW-1:0] sat_aw(input logic signed [SW-1:0] x);
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] lo;
		hi = {{(SW-AW+1){1'b0}}, {(AW-1){1'b1}}};
		lo = ~hi;
		if (x > hi) begin
			return hi[AW-1:0];
		end else if (x < lo) begin
			return lo[AW-1:0];
		end
		return x[AW-1:0];
	endfunction

	in_item_t              item_q;
	logic signed [DW-1:0]  nrm_q [3];
	logic signed [AW-1:0]  acc_q [3];
	logic signed [PW-1:0]  prod_q;
	logic signed [DOTW-1:0] dot_q;
	logic signed [DW-1:0]  wgt_q;
	out_item_t             out_q;
	logic                  out_valid_q;

	logic signed [DW-1:0]  li [3];
	logic signed [DW-1:0]  vec [3];
	logic signed [DW-1:0]  glow [3];
	logic signed [DW-1:0]  dot_sat;
	logic signed [AW-1:0]  a_op;
	logic signed [DW-1:0]  b_op;
	logic signed [PW-1:0]  prod_d;
	logic signed [QW-1:0]  q;
	logic signed [SW-1:0]  q_ext;
	logic signed [AW-1:0]  amb_sum [3];
	logic signed [AW-1:0]  dif_sum [3];
	logic signed [DW-1:0]  out_sum [3];
	logic [2:0]            acc_we;
	logic                  amb_we;

	// Per-channel views of the latched word and the glow registers.
	assign li[0]   = item_q.light_red;
	assign li[1]   = item_q.light_green;
	assign li[2]   = item_q.light_blue;
	assign vec[0]  = item_q.vec_x;
	assign vec[1]  = item_q.vec_y;
	assign vec[2]  = item_q.vec_z;
	assign glow[0] = cfg.glow_r;
	assign glow[1] = cfg.glow_g;
	assign glow[2] = cfg.glow_b;

	assign dot_sat = sat_dw({{(SW-DOTW){dot_q[DOTW-1]}}, dot_q});

	// Operand selection for the shared multiplier.
	always_comb begin
		case (ctrl.a_sel)
			A_VX:    a_op = {{(AW-DW){item_q.vec_x[DW-1]}}, item_q.vec_x};
			A_VY:    a_op = {{(AW-DW){item_q.vec_y[DW-1]}}, item_q.vec_y};
			A_VZ:    a_op = {{(AW-DW){item_q.vec_z[DW-1]}}, item_q.vec_z};
			A_DOT:   a_op = {{(AW-DW){dot_sat[DW-1]}}, dot_sat};
			A_LR:    a_op = {{(AW-DW){li[0][DW-1]}}, li[0]};
			A_LG:    a_op = {{(AW-DW){li[1][DW-1]}}, li[1]};
			A_LB:    a_op = {{(AW-DW){li[2][DW-1]}}, li[2]};
			A_ACC_R: a_op = acc_q[0];
			A_ACC_G: a_op = acc_q[1];
			A_ACC_B: a_op = acc_q[2];
			default: a_op = '0;
		endcase
		case (ctrl.b_sel)
			B_NX:    b_op = nrm_q[0];
			B_NY:    b_op = nrm_q[1];
			B_NZ:    b_op = nrm_q[2];
			B_REFL:  b_op = cfg.refl;
			B_WGT:   b_op = wgt_q;
			B_COL_R: b_op = cfg.col_r;
			B_COL_G: b_op = cfg.col_g;
			B_COL_B: b_op = cfg.col_b;
			default: b_op = '0;
		endcase
	end

	assign prod_d = a_op * b_op;

	// Product scaled by 1/4096 with floor rounding is the upper bits.
	assign q     = prod_q[PW-1:FB];
	assign q_ext = {q[QW-1], q};

	// Saturating adders per channel.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			amb_sum[i] = sat_aw({{(SW-AW){acc_q[i][AW-1]}}, acc_q[i]}
				+ {{(SW-DW){li[i][DW-1]}}, li[i]});
			dif_sum[i] = sat_aw({{(SW-AW){acc_q[i][AW-1]}}, acc_q[i]} + q_ext);
			out_sum[i] = sat_dw(q_ext + {{(SW-DW){glow[i][DW-1]}}, glow[i]});
		end
	end

	assign acc_we[0] = (ctrl.wb == WB_ACC_R);
	assign acc_we[1] = (ctrl.wb == WB_ACC_G);
	assign acc_we[2] = (ctrl.wb == WB_ACC_B);
	assign amb_we    = ctrl.amb && item_q.ambient_on;

	// Latch the accepted word.
	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= in_item;
		end
	end

	// Product, dot and weight registers.
	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= prod_d;
		end
		case (ctrl.wb)
			WB_DOT_CLR: dot_q <= q[DOTW-1:0];
			WB_DOT_ADD: dot_q <= dot_q + q[DOTW-1:0];
			WB_WGT:     wgt_q <= sat_dw(q_ext);
			default: ;
		endcase
	end

	// Normal and accumulator state; a begin word loads the normal and clears.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				nrm_q[i] <= '0;
				acc_q[i] <= '0;
			end
		end else if (ctrl.load_nrm) begin
			for (int i = 0; i < 3; i++) begin
				nrm_q[i] <= vec[i];
				acc_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < 3; i++) begin
				if (amb_we) begin
					acc_q[i] <= amb_sum[i];
				end else if (acc_we[i]) begin
					acc_q[i] <= dif_sum[i];
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		case (ctrl.wb)
			WB_OUT_R: out_q.out_red   <= out_sum[0];
			WB_OUT_G: out_q.out_green <= out_sum[1];
			WB_OUT_B: out_q.out_blue  <= out_sum[2];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Status back to the sequencer.
	assign stat.is_begin = (item_q.operation == OP_BEGIN);
	assign stat.no_diff  = !item_q.diffuse_on;
	assign stat.dot_le0  = dot_q[DOTW-1] || (dot_q == '0);
	assign stat.last     = item_q.last_item;
	assign stat.out_hold = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

[sv/lambert_light_accumulate.sv]
// A word that ends a point raises result valid once its microcode program has run the final-color
// steps; a light word with no diffuse flag or a dot not positive skips the diffuse steps on the way.
// A new word is taken only once the last is done; each word walks a microcode program in which
// every product goes through the single shared 24x16 multiplier, one per cycle.
// The final-color steps wait while an earlier result has not been taken.
// Reset (arst_n low, asynchronous) clears normal and accumulators and loads the register defaults.
// ----------------------------------------------------------------------------
// lambert_light_accumulate: Lambert shading of one point over a light stream
// Accumulates ambient and cosine-weighted diffuse light in Q12.12 and emits
// accumulator times surface color plus glow, saturated to Q4.12.
// ----------------------------------------------------------------------------
module lambert_light_accumulate import llac_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	llac_in_if.sink        stream,
	llac_out_if.source     result,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [ADW-1:0] paddr,
	input  logic [PDW-1:0] pwdata,
	output logic [PDW-1:0] prdata,
	output logic           pready
);

	cfg_t  cfg;
	ctrl_t ctrl;
	stat_t stat;
	logic  busy;
	logic  start;

	// A new word is taken only while the sequencer is idle.
	assign stream.ready = !busy;
	assign start        = stream.valid && stream.ready;

	llac_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	llac_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	llac_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (start),
		.in_item   (stream.item),
		.cfg       (cfg),
		.ctrl      (ctrl),
		.out_ready (result.ready),
		.stat      (stat),
		.out_valid (result.valid),
		.out_item  (result.item)
	);

endmodule

[sv/llac_chk.sv]
// ----------------------------------------------------------------------------
// llac_chk: port checker for the light accumulator
// Watches the word and result channels of the top level over time.
// ----------------------------------------------------------------------------
module llac_chk import llac_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	// A pending result stays until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before it was taken");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_item))
		else $error("stalled result changed");

	// An accepted word makes the block busy in the next cycle, so no word follows it back to back.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("word accepted back to back");

	// A result only appears out of work on an accepted word.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while idle");

endmodule

bind lambert_light_accumulate llac_chk u_llac_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (stream.valid),
	.in_ready  (stream.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_item  (result.item)
);

[tb/sv/lambert_light_accumulate_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lambert_light_accumulate_test: self-checking bench for the light accumulator
// Drives point sequences (begin word, lights, last flag) with random content and
// random idling on both channels, programs the shading registers over APB in
// several phases, and compares every result word against a bit-exact shading
// predictor kept inside the bench or the expected value given in a directed row.
// ----------------------------------------------------------------------------
module lambert_light_accumulate_test;
	import llac_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 11;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int LONG_STALL   = 300;
	localparam int PHASE_WORDS  = 130;
	localparam int NUM_REGS     = 7;
	localparam int REG_UNMAPPED = 7;
	localparam int MAX_REPORTS  = 10;

	typedef struct {
		in_item_t  w;
		bit        typed;
		out_item_t r;
	} stim_row_t;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           psel;
	logic           penable;
	logic           pwrite;
	logic [ADW-1:0] paddr;
	logic [PDW-1:0] pwdata;
	logic [PDW-1:0] prdata;
	logic           pready;

	llac_in_if  stream_if ();
	llac_out_if result_if ();

	// Predictor state: registers, held normal and color accumulators.
	cfg_t                 shade_cfg;
	logic signed [DW-1:0] nrm_q [3];
	logic signed [AW-1:0] acc_q [3];
	out_item_t            shade_q [$];

	int  err_count   = 0;
	int  cycle_count = 0;
	int  src_idle_pct = 0;
	int  snk_idle_pct = 0;
	bit  calm        = 1'b0;
	bit  hold_result = 1'b0;

	lambert_light_accumulate uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (stream_if),
		.result  (result_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Free-running clock.
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Run-away guard.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Saturate to a signed width.
	function automatic longint sat_to(input longint x, input int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (x > hi)
			return hi;
		if (x < lo)
			return lo;
		return x;
	endfunction

	// Q4.12 product, rounded toward minus infinity.
	function automatic longint mul_q(input longint a, input longint b);
		return (a * b) >>> FB;
	endfunction

	// Predict one accepted word; returns 1 when it ends a point.
	function automatic bit shade_step(input in_item_t w, output out_item_t r);
		longint dirv [3];
		longint li [3];
		longint col [3];
		longint glw [3];
		longint dot;
		longint wgt;
		int     k;
		r = '0;
		dirv[0] = $signed(w.vec_x);
		dirv[1] = $signed(w.vec_y);
		dirv[2] = $signed(w.vec_z);
		li[0] = $signed(w.light_red);
		li[1] = $signed(w.light_green);
		li[2] = $signed(w.light_blue);
		if (w.operation == OP_BEGIN) begin
			for (k = 0; k < 3; k++) begin
				nrm_q[k] = DW'(dirv[k]);
				acc_q[k] = '0;
			end
		end else begin
			if (w.ambient_on) begin
				for (k = 0; k < 3; k++)
					acc_q[k] = AW'(sat_to(longint'(acc_q[k]) + li[k], AW));
			end
			if (w.diffuse_on) begin
				dot = 0;
				for (k = 0; k < 3; k++)
					dot += mul_q(dirv[k], longint'(nrm_q[k]));
				dot = sat_to(dot, DW);
				// Light behind the surface adds no diffuse term.
				if (dot > 0) begin
					wgt = sat_to(mul_q(dot, longint'(shade_cfg.refl)), DW);
					for (k = 0; k < 3; k++)
						acc_q[k] = AW'(sat_to(longint'(acc_q[k]) + mul_q(li[k], wgt), AW));
				end
			end
		end
		if (!w.last_item)
			return 1'b0;
		col[0] = shade_cfg.col_r;
		col[1] = shade_cfg.col_g;
		col[2] = shade_cfg.col_b;
		glw[0] = shade_cfg.glow_r;
		glw[1] = shade_cfg.glow_g;
		glw[2] = shade_cfg.glow_b;
		r.out_red   = DW'(sat_to(mul_q(longint'(acc_q[0]), col[0]) + glw[0], DW));
		r.out_green = DW'(sat_to(mul_q(longint'(acc_q[1]), col[1]) + glw[1], DW));
		r.out_blue  = DW'(sat_to(mul_q(longint'(acc_q[2]), col[2]) + glw[2], DW));
		return 1'b1;
	endfunction

	// Predicted register contents by index.
	function automatic logic [DW-1:0] cfg_value(input int idx);
		case (reg_idx_t'(idx))
			REG_REFL:   return shade_cfg.refl;
			REG_COL_R:  return shade_cfg.col_r;
			REG_COL_G:  return shade_cfg.col_g;
			REG_COL_B:  return shade_cfg.col_b;
			REG_GLOW_R: return shade_cfg.glow_r;
			REG_GLOW_G: return shade_cfg.glow_g;
			default:    return shade_cfg.glow_b;
		endcase
	endfunction

	task automatic note_mismatch(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("mismatch: %s", msg);
	endtask

	task automatic check_field(input string name, input logic [DW-1:0] e, input logic [DW-1:0] a);
		if (a !== e)
			note_mismatch($sformatf("%s expected %h actual %h", name, e, a));
	endtask

	// Result checker: each result word against the oldest expectation.
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
			if (shade_q.size() == 0) begin
				note_mismatch($sformatf("unexpected result %h", result_if.item));
			end else begin
				e = shade_q.pop_front();
				check_field("out_red", e.out_red, result_if.item.out_red);
				check_field("out_green", e.out_green, result_if.item.out_green);
				check_field("out_blue", e.out_blue, result_if.item.out_blue);
			end
		end
	end

	// Result receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_result) begin
				result_if.ready <= 1'b0;
				repeat (LONG_STALL) @(negedge clk);
				hold_result = 1'b0;
				result_if.ready <= 1'b1;
			end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
				result_if.ready <= 1'b0;
				repeat ($urandom_range(1, 12) - 1) @(negedge clk);
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	// One APB access; a read is checked against the predicted register.
	task automatic apb_access(input bit wr, input int idx, input logic [DW-1:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADW'(idx * 4);
		pwdata  <= {{(PDW - DW){v[DW-1]}}, v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (wr) begin
			// Writes past the register list are dropped.
			case (reg_idx_t'(idx))
				REG_REFL:   shade_cfg.refl   = v;
				REG_COL_R:  shade_cfg.col_r  = v;
				REG_COL_G:  shade_cfg.col_g  = v;
				REG_COL_B:  shade_cfg.col_b  = v;
				REG_GLOW_R: shade_cfg.glow_r = v;
				REG_GLOW_G: shade_cfg.glow_g = v;
				REG_GLOW_B: shade_cfg.glow_b = v;
				default: ;
			endcase
		end else begin
			check_field($sformatf("register %0d", idx), cfg_value(idx), prdata[DW-1:0]);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Offer one word, wait for acceptance, then record its expected result.
	task automatic send_word(input in_item_t w, input bit typed, input out_item_t r);
		out_item_t p;
		bit        emits;
		int        gap;
		if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			stream_if.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		stream_if.valid <= 1'b1;
		stream_if.item  <= w;
		do @(posedge clk); while (stream_if.ready !== 1'b1);
		emits = shade_step(w, p);
		if (emits)
			shade_q.push_back(typed ? r : p);
	endtask

	// Drop valid right after the last accepted word.
	task automatic stream_stop();
		@(negedge clk);
		stream_if.valid <= 1'b0;
	endtask

	task automatic drain();
		while (shade_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Field value biased toward extremes and unit-scale vectors.
	function automatic logic [DW-1:0] rand_q();
		case ($urandom_range(0, 7))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2, 3:    return DW'(int'($urandom_range(0, 16384)) - 8192);
			default: return DW'($urandom);
		endcase
	endfunction

	function automatic in_item_t rand_word(input logic op, input logic lst);
		in_item_t w;
		w.operation   = op;
		w.vec_x       = rand_q();
		w.vec_y       = rand_q();
		w.vec_z       = rand_q();
		w.light_red   = rand_q();
		w.light_green = rand_q();
		w.light_blue  = rand_q();
		w.ambient_on  = 1'($urandom_range(0, 1));
		w.diffuse_on  = ($urandom_range(0, 3) != 0);
		w.last_item   = lst;
		return w;
	endfunction

	function automatic int idle_pick(input int lo, input int hi);
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return lo;
			default: return hi;
		endcase
	endfunction

	// Random part: mostly whole points, some stray and broken words.
	task automatic drive_random(input int quota);
		int        sent;
		int        nl;
		int        k;
		int        kind;
		logic      sgn;
		in_item_t  w;
		in_item_t  lw;
		out_item_t none;
		none = '0;
		sent = 0;
		while (sent < quota) begin
			if (!calm && $urandom_range(0, 9) == 0) begin
				src_idle_pct = idle_pick(15, 40);
				snk_idle_pct = idle_pick(3, 10);
			end
			kind = $urandom_range(0, 19);
			if (kind < 14) begin
				// Ordinary point with a few lights.
				nl = $urandom_range(0, 5);
				send_word(rand_word(OP_BEGIN, nl == 0), 1'b0, none);
				sent++;
				for (k = 0; k < nl; k++) begin
					send_word(rand_word(OP_LIGHT, k == nl - 1), 1'b0, none);
					sent++;
				end
			end else if (kind < 17) begin
				// Long run of one aligned light to push the accumulators to saturation.
				nl = $urandom_range(20, 40);
				sgn = 1'($urandom_range(0, 1));
				w = rand_word(OP_BEGIN, 1'b0);
				w.vec_x = sgn ? 16'h8000 : 16'h7FFF;
				w.vec_y = w.vec_x;
				w.vec_z = w.vec_x;
				send_word(w, 1'b0, none);
				sent++;
				lw = rand_word(OP_LIGHT, 1'b0);
				lw.vec_x = w.vec_x;
				lw.vec_y = w.vec_x;
				lw.vec_z = w.vec_x;
				lw.diffuse_on = 1'b1;
				for (k = 0; k < nl; k++) begin
					lw.last_item = (k == nl - 1);
					send_word(lw, 1'b0, none);
					sent++;
				end
			end else if (kind == 17) begin
				send_word(rand_word(OP_LIGHT, 1'($urandom_range(0, 1))), 1'b0, none);
				sent++;
			end else if (kind == 18) begin
				send_word(rand_word(OP_BEGIN, 1'b0), 1'b0, none);
				sent++;
			end else begin
				send_word(rand_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))),
					1'b0, none);
				sent++;
			end
		end
	endtask

	function automatic stim_row_t drow(input logic op, input int vx, input int vy, input int vz,
			input int lr, input int lg, input int lb, input logic amb, input logic dif,
			input logic lst);
		stim_row_t s;
		s.w.operation   = op;
		s.w.vec_x       = DW'(vx);
		s.w.vec_y       = DW'(vy);
		s.w.vec_z       = DW'(vz);
		s.w.light_red   = DW'(lr);
		s.w.light_green = DW'(lg);
		s.w.light_blue  = DW'(lb);
		s.w.ambient_on  = amb;
		s.w.diffuse_on  = dif;
		s.w.last_item   = lst;
		s.typed         = 1'b0;
		s.r             = '0;
		return s;
	endfunction

	function automatic stim_row_t with_exp(input stim_row_t s, input int r, input int g, input int b);
		s.typed       = 1'b1;
		s.r.out_red   = DW'(r);
		s.r.out_green = DW'(g);
		s.r.out_blue  = DW'(b);
		return s;
	endfunction

	// Main sequence.
	initial begin
		stim_row_t     dir_rows [$];
		logic [DW-1:0] vals [NUM_REGS];
		int            ph;
		int            i;

		arst_n         = 1'b0;
		stream_if.valid = 1'b0;
		stream_if.item  = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;

		shade_cfg.refl   = REFL_RST;
		shade_cfg.col_r  = COL_R_RST;
		shade_cfg.col_g  = COL_G_RST;
		shade_cfg.col_b  = COL_B_RST;
		shade_cfg.glow_r = GLOW_RST;
		shade_cfg.glow_g = GLOW_RST;
		shade_cfg.glow_b = GLOW_RST;
		for (i = 0; i < 3; i++) begin
			nrm_q[i] = '0;
			acc_q[i] = '0;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table, run with the reset register values.
		// Point with no lights right after reset: glow only.
		dir_rows.push_back(with_exp(drow(OP_BEGIN, 0, 0, 0, 32767, -32768, 5, 1, 1, 1), 0, 0, 0));
		// Light with no begin: zero normal, so ambient only at full intensity.
		dir_rows.push_back(with_exp(drow(OP_LIGHT, 32767, -32768, 1234, 32767, 32767, 32767,
			1, 1, 1), 0, 19271, 21103));
		// Accumulators survive a result when no begin follows.
		dir_rows.push_back(with_exp(drow(OP_LIGHT, -1, 7, 9, -32768, 100, 200, 0, 0, 1),
			0, 19271, 21103));
		dir_rows.push_back(drow(OP_BEGIN, 4096, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(drow(OP_LIGHT, 4096, 0, 0, 4096, 4096, 4096, 0, 1, 0));
		// Light from behind: ambient still applies.
		dir_rows.push_back(drow(OP_LIGHT, -4096, 0, 0, -4096, -4096, -4096, 1, 1, 1));
		dir_rows.push_back(drow(OP_BEGIN, 32767, 32767, 32767, 0, 0, 0, 1, 0, 0));
		// Dot product saturates high, then low.
		dir_rows.push_back(drow(OP_LIGHT, 32767, 32767, 32767, -32768, -32768, -32768, 1, 1, 0));
		dir_rows.push_back(drow(OP_LIGHT, -32768, -32768, -32768, 32767, -32768, 0, 0, 1, 1));
		dir_rows.push_back(drow(OP_BEGIN, -32768, -32768, -32768, 1, 1, 1, 0, 1, 0));
		dir_rows.push_back(drow(OP_LIGHT, -32768, -32768, -32768, 32767, 32767, 32767, 1, 1, 0));
		dir_rows.push_back(drow(OP_LIGHT, -32768, -32768, -32768, 32767, -32768, 32767, 1, 1, 0));
		// Zero dot product adds nothing diffuse.
		dir_rows.push_back(drow(OP_LIGHT, 0, 0, 0, 1, -1, 0, 1, 1, 1));
		dir_rows.push_back(with_exp(drow(OP_BEGIN, 0, 4096, 0, -1, -1, -1, 1, 1, 1), 0, 0, 0));
		dir_rows.push_back(drow(OP_LIGHT, 0, 2048, 0, 4096, 8192, -8192, 0, 1, 1));
		dir_rows.push_back(drow(OP_LIGHT, 1, -1, 1, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(drow(OP_LIGHT, 100, 200, 300, -1, 1, -1, 1, 0, 1));

		foreach (dir_rows[i])
			send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r);
		stream_stop();
		drain();

		// Random phases, each under its own register setting.
		for (ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				for (i = 0; i < NUM_REGS; i++) begin
					case (ph)
						1:       vals[i] = DW'($urandom_range(0, 8192));
						2:       vals[i] = 16'h7FFF;
						3:       vals[i] = 16'h8000;
						default: vals[i] = DW'($urandom);
					endcase
				end
				if (ph == 1) begin
					vals[REG_REFL]  = 16'd4096;
					vals[REG_COL_B] = 16'hF000;
					apb_access(1'b1, REG_UNMAPPED, 16'h1234);
				end
				for (i = 0; i < NUM_REGS; i++)
					apb_access(1'b1, i, vals[i]);
				for (i = 0; i < NUM_REGS; i++)
					apb_access(1'b0, i, '0);
			end
			calm = (ph == 5);
			src_idle_pct = calm ? 0 : 15;
			snk_idle_pct = calm ? 0 : 3;
			if (ph == 2)
				hold_result = 1'b1;
			if (ph == 4) begin
				drive_random(PHASE_WORDS / 2);
				stream_stop();
				// Sender holds until every outstanding result is back.
				while (shade_q.size() != 0)
					@(posedge clk);
				drive_random(PHASE_WORDS / 2);
			end else begin
				drive_random(PHASE_WORDS);
			end
			stream_stop();
			drain();
		end

		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[sim.f]
sv/llac_pkg.sv
sv/llac_if.sv
sv/llac_cfg.sv
sv/llac_seq.sv
sv/llac_dpath.sv
sv/lambert_light_accumulate.sv
sv/llac_chk.sv
tb/sv/lambert_light_accumulate_test.sv
